### hdl/cic_pkg.sv
// shared types, register offsets and a helper function of the interrupt controller
package cic_pkg;

  localparam int unsigned GROUP_BITS   = 32;
  localparam int unsigned SOURCE_COUNT = 96;
  localparam int unsigned SRC_W        = $clog2(SOURCE_COUNT);
  localparam int unsigned BIT_W        = $clog2(GROUP_BITS);

  localparam int unsigned SUMMARY_ONE_BIT = 8;
  localparam int unsigned SUMMARY_TWO_BIT = 9;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_QUERY = 2'd2
  } opcode_t;

  localparam logic [3:0] OFF_BASE_PEND = 4'd0;
  localparam logic [3:0] OFF_ONE_PEND  = 4'd1;
  localparam logic [3:0] OFF_TWO_PEND  = 4'd2;
  localparam logic [3:0] OFF_EN_ONE    = 4'd4;
  localparam logic [3:0] OFF_EN_TWO    = 4'd5;
  localparam logic [3:0] OFF_EN_BASE   = 4'd6;
  localparam logic [3:0] OFF_DIS_ONE   = 4'd7;
  localparam logic [3:0] OFF_DIS_TWO   = 4'd8;
  localparam logic [3:0] OFF_DIS_BASE  = 4'd9;

  typedef struct packed {
    opcode_t     opcode;
    logic [3:0]  word_offset;
    logic [31:0] write_data;
    logic [31:0] raw_base_lines;
    logic [31:0] raw_group_one_lines;
    logic [31:0] raw_group_two_lines;
  } req_t;

  typedef struct packed {
    logic [31:0]      read_data;
    logic             source_found;
    logic [SRC_W-1:0] source_number;
  } rsp_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] one;
    logic [31:0] two;
  } masks_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [BIT_W-1:0] lowest_bit(input logic [GROUP_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = GROUP_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

### hdl/cic_masks.sv
// enable mask registers with set and clear write ports
module cic_masks import cic_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   fire,
  input  req_t   req,
  output masks_t masks
);

  masks_t masks_next;

  always_comb begin
    masks_next = masks;
    if (fire && req.opcode == OP_WRITE) begin
      unique case (req.word_offset)
        OFF_EN_ONE:   masks_next.one  = masks.one  | req.write_data;
        OFF_EN_TWO:   masks_next.two  = masks.two  | req.write_data;
        OFF_EN_BASE:  masks_next.base = masks.base | req.write_data;
        OFF_DIS_ONE:  masks_next.one  = masks.one  & ~req.write_data;
        OFF_DIS_TWO:  masks_next.two  = masks.two  & ~req.write_data;
        OFF_DIS_BASE: masks_next.base = masks.base & ~req.write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      masks <= '0;
    end else begin
      masks <= masks_next;
    end
  end

endmodule

### hdl/cic_query.sv
// read decode and first-pending-source priority search
module cic_query import cic_pkg::*; (
  input  req_t   req,
  input  masks_t masks,
  output rsp_t   rsp
);

  logic [31:0]      one_act;
  logic [31:0]      two_act;
  logic [31:0]      base_pend;
  logic [31:0]      base_act;
  logic [BIT_W-1:0] base_idx;
  logic [SRC_W-1:0] number;

  assign one_act = req.raw_group_one_lines & masks.one;
  assign two_act = req.raw_group_two_lines & masks.two;

  // summary bits replace raw bits 8 and 9
  always_comb begin
    base_pend                  = req.raw_base_lines;
    base_pend[SUMMARY_ONE_BIT] = |one_act;
    base_pend[SUMMARY_TWO_BIT] = |two_act;
  end

  assign base_act = base_pend & masks.base;
  assign base_idx = lowest_bit(base_act);

  // a set summary bit always has a set line behind it
  always_comb begin
    if (base_idx == BIT_W'(SUMMARY_ONE_BIT)) begin
      number = SRC_W'(GROUP_BITS) + SRC_W'(lowest_bit(one_act));
    end else if (base_idx == BIT_W'(SUMMARY_TWO_BIT)) begin
      number = SRC_W'(2 * GROUP_BITS) + SRC_W'(lowest_bit(two_act));
    end else begin
      number = SRC_W'(base_idx);
    end
  end

  always_comb begin
    rsp = '0;
    unique case (req.opcode)
      OP_READ: begin
        unique case (req.word_offset)
          OFF_BASE_PEND: rsp.read_data = base_pend;
          OFF_ONE_PEND:  rsp.read_data = req.raw_group_one_lines;
          OFF_TWO_PEND:  rsp.read_data = req.raw_group_two_lines;
          default:       rsp.read_data = '0;
        endcase
      end
      OP_QUERY: begin
        rsp.source_found  = |base_act;
        rsp.source_number = (|base_act) ? number : '0;
      end
      default: ;
    endcase
  end

endmodule

### hdl/cascaded_interrupt_controller_top.sv
// Cascaded interrupt controller for 96 sources in three 32-bit groups.
// Request channel (req_valid/req_ready/req): one transaction is a register
// read, a register write (enable set at offsets 4..6, enable clear at 7..9)
// or a next-pending-source query, together with the raw source lines.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one transaction per
// request, in request order, with read data or the found source number.
// A request is held in the input register, then its response in the result
// register.
// Throughput: one transaction per cycle while the receiver does not stall,
// set by the single pass of masking and priority encoding between them.
// Mask writes take effect at the result stage, so the following request
// already sees them.
// Reset (rst, synchronous) clears all enable masks and empties both stages.
// When the receiver stalls, the result register holds its response and the
// input register keeps one more request; req_ready drops once both are full.
module cascaded_interrupt_controller_top import cic_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic   stage_valid;
  req_t   stage_req;
  logic   advance;
  masks_t masks;
  rsp_t   result;

  assign advance   = stage_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (req_ready) stage_valid <= req_valid;
      if (advance) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) stage_req <= req;
    if (advance) rsp <= result;
  end

  cic_masks u_masks (
    .clk   (clk),
    .rst   (rst),
    .fire  (advance),
    .req   (stage_req),
    .masks (masks)
  );

  cic_query u_query (
    .req   (stage_req),
    .masks (masks),
    .rsp   (result)
  );

endmodule

### hdl/cic_checker.sv
// port-level checker of the interrupt controller and its bind
module cic_checker import cic_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_found_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.source_found |-> rsp.read_data == '0)
    else $error("query response carries read data");

  // summary sources are never reported and numbers stay in range
  a_number_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.source_found |->
      rsp.source_number != SRC_W'(SUMMARY_ONE_BIT) &&
      rsp.source_number != SRC_W'(SUMMARY_TWO_BIT) &&
      rsp.source_number < SRC_W'(SOURCE_COUNT))
    else $error("illegal source number");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.source_found |-> rsp.source_number == '0)
    else $error("source number without a found source");

  // both stages empty and ready for a request after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("not empty after reset");

endmodule

bind cascaded_interrupt_controller_top cic_checker u_cic_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

### tb/cascaded_interrupt_controller_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the cascaded interrupt controller
module cascaded_interrupt_controller_top_test;
  import cic_pkg::*;

  localparam opcode_t     OP_UNUSED    = opcode_t'(2'd3);
  localparam logic [31:0] ONES         = 32'hFFFF_FFFF;
  localparam int          RANDOM_ITEMS = 1750;
  localparam int          CALM_ITEMS   = 200;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          SETTLE_CYCLES = 10;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          MAX_REPORTS  = 50;

  typedef struct {
    req_t item;
    bit   fixed;
    rsp_t want;
  } vector_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // controller state as the predictor sees it
  logic [31:0] mask_base;
  logic [31:0] mask_one;
  logic [31:0] mask_two;

  rsp_t    awaited_responses[$];
  vector_t directed_rows[$];
  int      mismatches = 0;
  int      cycle_count = 0;
  int      idle_rate = 0;
  bit      calm = 1'b0;
  bit      hold_request = 1'b0;
  bit      holding = 1'b0;

  cascaded_interrupt_controller_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("cycle %0d: %s: want %h got %h", cycle_count, what, want, got);
  endtask

  function automatic int lowest_line(input logic [31:0] v);
    for (int i = 0; i < GROUP_BITS; i++) begin
      if (v[i]) return i;
    end
    return -1;
  endfunction

  // works out the response of one transaction and applies any mask write
  function automatic rsp_t predict_response(input req_t r);
    rsp_t        res;
    logic [31:0] pend;
    int          hit;
    res  = '0;
    pend = r.raw_base_lines;
    pend[SUMMARY_ONE_BIT] = |(r.raw_group_one_lines & mask_one);
    pend[SUMMARY_TWO_BIT] = |(r.raw_group_two_lines & mask_two);
    case (r.opcode)
      OP_READ: begin
        case (r.word_offset)
          OFF_BASE_PEND: res.read_data = pend;
          OFF_ONE_PEND:  res.read_data = r.raw_group_one_lines;
          OFF_TWO_PEND:  res.read_data = r.raw_group_two_lines;
          default: ;
        endcase
      end
      OP_WRITE: begin
        case (r.word_offset)
          OFF_EN_ONE:   mask_one  = mask_one | r.write_data;
          OFF_EN_TWO:   mask_two  = mask_two | r.write_data;
          OFF_EN_BASE:  mask_base = mask_base | r.write_data;
          OFF_DIS_ONE:  mask_one  = mask_one & ~r.write_data;
          OFF_DIS_TWO:  mask_two  = mask_two & ~r.write_data;
          OFF_DIS_BASE: mask_base = mask_base & ~r.write_data;
          default: ;
        endcase
      end
      OP_QUERY: begin
        // a set summary bit always has a group line behind it
        hit = lowest_line(pend & mask_base);
        res.source_found = (hit >= 0);
        if (hit == int'(SUMMARY_ONE_BIT))
          res.source_number = SRC_W'(GROUP_BITS
                              + lowest_line(r.raw_group_one_lines & mask_one));
        else if (hit == int'(SUMMARY_TWO_BIT))
          res.source_number = SRC_W'(2 * GROUP_BITS
                              + lowest_line(r.raw_group_two_lines & mask_two));
        else if (hit >= 0)
          res.source_number = SRC_W'(hit);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic vector_t dir_row(input opcode_t op, input logic [3:0] off,
                                      input logic [31:0] data, input logic [31:0] r0,
                                      input logic [31:0] r1, input logic [31:0] r2,
                                      input bit fixed, input logic [31:0] rd,
                                      input logic found, input int num);
    vector_t v;
    v.item  = '{op, off, data, r0, r1, r2};
    v.fixed = fixed;
    v.want  = '{rd, found, SRC_W'(num)};
    return v;
  endfunction

  function automatic logic [31:0] random_lines();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom & $urandom & $urandom;
      2: v = 32'd1 << $urandom_range(0, 31);
      3: v = '0;
      4: v = ONES;
      default: v = $urandom & $urandom & $urandom & $urandom & $urandom;
    endcase
    return v;
  endfunction

  function automatic vector_t random_vector();
    vector_t v;
    int      pick;
    pick = $urandom_range(0, 99);
    v.fixed = 1'b0;
    v.want  = '0;
    v.item.word_offset         = 4'($urandom_range(0, 15));
    v.item.write_data          = random_lines();
    v.item.raw_base_lines      = random_lines();
    v.item.raw_group_one_lines = random_lines();
    v.item.raw_group_two_lines = random_lines();
    if (pick < 40) begin
      v.item.opcode = OP_QUERY;
    end else if (pick < 65) begin
      v.item.opcode = OP_WRITE;
      if ($urandom_range(0, 99) < 85)
        v.item.word_offset = 4'($urandom_range(OFF_EN_ONE, OFF_DIS_BASE));
    end else if (pick < 95) begin
      v.item.opcode = OP_READ;
      if ($urandom_range(0, 99) < 80)
        v.item.word_offset = 4'($urandom_range(OFF_BASE_PEND, OFF_TWO_PEND));
    end else begin
      v.item.opcode = OP_UNUSED;
    end
    return v;
  endfunction

  task automatic send_item(input vector_t v);
    rsp_t predicted;
    int   gap;
    if (!calm && !holding && !hold_request && $urandom_range(0, 99) < idle_rate) begin
      gap = $urandom_range(1, 12);
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       = v.item;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    predicted = predict_response(v.item);
    awaited_responses.push_back(v.fixed ? v.want : predicted);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    req_valid = 1'b0;
    while (awaited_responses.size() != 0) @(negedge clk);
  endtask

  // receiver side: random stall bursts, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp_ready = 1'b0;
      end else if (hold_request) begin
        holding      = 1'b1;
        hold_request = 1'b0;
        rsp_ready    = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holding = 1'b0;
      end else if (calm) begin
        rsp_ready = 1'b1;
      end else if (stall_left > 0) begin
        rsp_ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 299) < idle_rate) begin
        stall_left = $urandom_range(1, 12) - 1;
        rsp_ready  = 1'b0;
      end else begin
        rsp_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_responses.size() == 0) begin
        report_mismatch("response with nothing awaited", '0, rsp.read_data);
      end else begin
        want = awaited_responses.pop_front();
        if (rsp.read_data !== want.read_data)
          report_mismatch("read_data", want.read_data, rsp.read_data);
        if (rsp.source_found !== want.source_found)
          report_mismatch("source_found", 32'(want.source_found), 32'(rsp.source_found));
        if (rsp.source_number !== want.source_number)
          report_mismatch("source_number", 32'(want.source_number),
                          32'(rsp.source_number));
      end
    end
  end

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    mask_base = '0;
    mask_one  = '0;
    mask_two  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // masks are all clear after reset
    directed_rows.push_back(dir_row(OP_READ, OFF_BASE_PEND, '0, ONES, ONES, ONES,
                                    1, 32'hFFFF_FCFF, 0, 0));
    directed_rows.push_back(dir_row(OP_READ, OFF_ONE_PEND, '0, '0, ONES, '0,
                                    1, ONES, 0, 0));
    directed_rows.push_back(dir_row(OP_READ, OFF_TWO_PEND, '0, '0, '0, 32'hA5A5_A5A5,
                                    1, 32'hA5A5_A5A5, 0, 0));
    directed_rows.push_back(dir_row(OP_READ, 4'd3, ONES, ONES, ONES, ONES, 1, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_READ, OFF_EN_BASE, ONES, ONES, ONES, ONES,
                                    1, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_READ, 4'd15, ONES, ONES, ONES, ONES, 1, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_QUERY, 4'd0, ONES, ONES, ONES, ONES, 1, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_WRITE, OFF_EN_BASE, ONES, '0, '0, '0, 1, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_QUERY, 4'd0, '0, ONES, '0, '0, 1, '0, 1, 0));
    directed_rows.push_back(dir_row(OP_QUERY, 4'd0, '0, 32'h8000_0000, '0, '0,
                                    1, '0, 1, 31));
    // summary lines alone are never a source, groups still masked
    directed_rows.push_back(dir_row(OP_QUERY, 4'd0, '0, 32'h0000_0300, ONES, ONES,
                                    1, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_WRITE, OFF_EN_ONE, ONES, '0, '0, '0, 1, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_WRITE, OFF_EN_TWO, ONES, '0, '0, '0, 1, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_QUERY, 4'd0, '0, '0, 32'h8000_0000, '0,
                                    1, '0, 1, 63));
    directed_rows.push_back(dir_row(OP_QUERY, 4'd0, '0, '0, '0, 32'h8000_0000,
                                    1, '0, 1, 95));
    directed_rows.push_back(dir_row(OP_QUERY, 4'd0, '0, '0, 32'h8000_0000, 32'h1,
                                    1, '0, 1, 63));
    directed_rows.push_back(dir_row(OP_QUERY, 4'd0, '0, 32'h0000_0400, '0, 32'h1,
                                    1, '0, 1, 64));
    directed_rows.push_back(dir_row(OP_QUERY, 4'd0, '0, 32'h0000_0080, 32'h1, '0,
                                    1, '0, 1, 7));
    directed_rows.push_back(dir_row(OP_READ, OFF_BASE_PEND, '0, '0, 32'h1, '0,
                                    1, 32'h0000_0100, 0, 0));
    directed_rows.push_back(dir_row(OP_WRITE, OFF_DIS_ONE, ONES, '0, '0, '0, 1, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_WRITE, OFF_DIS_TWO, 32'hFFFF_0000, '0, '0, '0,
                                    1, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_WRITE, OFF_DIS_BASE, 32'h1, '0, '0, '0,
                                    1, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_QUERY, 4'd0, '0, 32'h1, ONES, 32'h0001_0003,
                                    0, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_WRITE, OFF_BASE_PEND, ONES, '0, '0, '0,
                                    1, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_UNUSED, OFF_EN_BASE, ONES, ONES, ONES, ONES,
                                    1, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_WRITE, OFF_DIS_BASE, ONES, '0, '0, '0,
                                    1, '0, 0, 0));
    directed_rows.push_back(dir_row(OP_QUERY, 4'd0, '0, ONES, ONES, ONES, 0, '0, 0, 0));

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    wait_for_drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_rate = 0;
          1: idle_rate = 8;
          default: idle_rate = 30;
        endcase
      end
      if (n == 300 || n == 1100) hold_request = 1'b1;
      if (n == 700) wait_for_drain();
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      send_item(random_vector());
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
